@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// A property checked on every rising clock edge, including during reset.
`define ASSERT_CLK_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: label");

`endif

@@ hdl/tet_pkg.sv @@
package tet_pkg;

  // One command or operand byte.
  typedef logic [7:0] cmd_t;

  // Internal command codes that need special handling.
  localparam cmd_t CmdBasicLast   = 8'h11;
  localparam cmd_t CmdVolume      = 8'h0C;
  localparam cmd_t CmdGlobalVol   = 8'h10;
  localparam cmd_t CmdPanSlide    = 8'h14;
  localparam cmd_t CmdPanSlideAlt = 8'h51;
  localparam cmd_t CmdRetrig      = 8'h15;
  localparam cmd_t CmdTempo       = 8'h16;
  localparam cmd_t CmdKeepA       = 8'h19;
  localparam cmd_t CmdKeepB       = 8'h1B;
  localparam cmd_t CmdSpeed       = 8'h1C;
  localparam cmd_t CmdTremor      = 8'h1D;
  localparam cmd_t CmdOffset      = 8'h1F;
  localparam cmd_t CmdArpeggio    = 8'h20;
  localparam cmd_t CmdJump        = 8'h2B;
  localparam cmd_t CmdExtFirst    = 8'h30;
  localparam cmd_t CmdExtLast     = 8'h3F;
  localparam cmd_t CmdXFineUp     = 8'h41;
  localparam cmd_t CmdXFineDown   = 8'h42;
  localparam cmd_t CmdPortaUp     = 8'h43;
  localparam cmd_t CmdPortaDown   = 8'h44;
  localparam cmd_t CmdVolSlideUp  = 8'h45;
  localparam cmd_t CmdVolSlideDn  = 8'h46;
  localparam cmd_t CmdPortaUpAlt  = 8'h47;
  localparam cmd_t CmdPortaDnAlt  = 8'h48;
  localparam cmd_t CmdVolSlide    = 8'h49;
  localparam cmd_t CmdFineVolUp   = 8'h4B;
  localparam cmd_t CmdFineVolDn   = 8'h4C;
  localparam cmd_t CmdSlideUpQtr  = 8'h4D;
  localparam cmd_t CmdSlideDnQtr  = 8'h4E;

  // Target command codes.
  localparam cmd_t OutNone        = 8'h00;
  localparam cmd_t OutPortaUp     = 8'h01;
  localparam cmd_t OutPortaDown   = 8'h02;
  localparam cmd_t OutOffset      = 8'h09;
  localparam cmd_t OutVolSlide    = 8'h0A;
  localparam cmd_t OutJump        = 8'h0B;
  localparam cmd_t OutExtended    = 8'h0E;
  localparam cmd_t OutSpeed       = 8'h0F;
  localparam cmd_t OutXFine       = 8'h21;

  // Operand limits and nibble bases.
  localparam cmd_t TempoMin       = 8'd32;
  localparam cmd_t SpeedMax       = 8'd31;
  localparam cmd_t FineThreshold  = 8'hE0;
  localparam cmd_t BaseUp         = 8'h10;
  localparam cmd_t BaseDown       = 8'h20;
  localparam cmd_t BaseFineVolUp  = 8'hA0;
  localparam cmd_t BaseFineVolDn  = 8'hB0;
  localparam logic [8:0] ScaleDiv = 9'd255;

endpackage

@@ hdl/tracker_effect_translator.sv @@
// Effect command translator.
// Input channel: in_valid_i / in_stall_o carry effect_in_i and operand_in_i;
// a transfer happens at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry effect_out_o and
// operand_out_o; the result is taken at an edge with out_valid_o high and
// out_stall_i low. Every input transfer gives exactly one result, in order.
// A result passes from the input register through the translation logic into
// the result register, which offers it on out_valid_o until it is taken.
// Throughput: one item per cycle while out_stall_i is low; two register stages.
// When the receiver stalls, the result register holds its value, the input
// register fills, and in_stall_o rises until the result is taken.
// Reset (rst_ni low) empties both stages at once; any item in flight is
// dropped and out_valid_o goes low.
module tracker_effect_translator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tet_pkg::cmd_t effect_in_i,
  input  tet_pkg::cmd_t operand_in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tet_pkg::cmd_t effect_out_o,
  output tet_pkg::cmd_t operand_out_o
);
  import tet_pkg::*;

  logic in_valid_q;
  cmd_t in_effect_q;
  cmd_t in_operand_q;
  logic out_valid_q;
  logic out_valid_d;
  cmd_t out_effect_q;
  cmd_t out_operand_q;
  cmd_t xl_effect;
  cmd_t xl_operand;
  logic out_advance;
  logic in_take;

  // The result stage can load when it is empty or its result leaves now.
  assign out_advance = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !out_advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_d = in_valid_q || (out_valid_q && out_stall_i);

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_advance || in_take) begin
        in_valid_q <= in_take;
      end
      if (out_advance) begin
        out_valid_q <= out_valid_d;
      end
    end
  end

  // Input register captures each transfer.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_effect_q  <= effect_in_i;
      in_operand_q <= operand_in_i;
    end
  end

  tet_xlate u_xlate (
    .effect_i  (in_effect_q),
    .operand_i (in_operand_q),
    .effect_o  (xl_effect),
    .operand_o (xl_operand)
  );

  // Result register holds steady while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      out_effect_q  <= xl_effect;
      out_operand_q <= xl_operand;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign effect_out_o  = out_effect_q;
  assign operand_out_o = out_operand_q;

endmodule

@@ hdl/tet_xlate.sv @@
module tet_xlate (
  input  tet_pkg::cmd_t effect_i,
  input  tet_pkg::cmd_t operand_i,
  output tet_pkg::cmd_t effect_o,
  output tet_pkg::cmd_t operand_o
);
  import tet_pkg::*;

  logic [3:0] hi;
  logic [3:0] lo;
  logic [8:0] scale_rem;
  cmd_t       scaled;
  logic       up;
  cmd_t       base;
  cmd_t       fine_vol;
  logic [3:0] x_nib;
  logic       bad_a;
  logic       bad_b;
  cmd_t       oe;
  cmd_t       op;

  assign hi = operand_i[7:4];
  assign lo = operand_i[3:0];

  // Volume rescale operand*64/255: the quotient estimate operand>>2 is at most
  // one short, and the remainder stays below twice the divisor.
  assign scale_rem = {1'b0, operand_i[1:0], 6'b0} + {3'b0, operand_i[7:2]};
  assign scaled    = {2'b0, operand_i[7:2]} + ((scale_rem >= ScaleDiv) ? 8'd1 : 8'd0);

  // Fine volume operand is the quarter value limited to one nibble.
  assign fine_vol = (operand_i[7:6] != 2'b00) ? 8'h0F : {4'h0, operand_i[5:2]};

  // Volume slide nibble patterns: bad_a has an F nibble beside a nonzero one, bad_b an F nibble beside a zero one.
  assign bad_a = ((lo == 4'hF) && (hi != 4'h0)) || ((hi == 4'hF) && (lo != 4'h0));
  assign bad_b = ((lo == 4'hF) && (hi == 4'h0)) || ((hi == 4'hF) && (lo == 4'h0));

  // Command translation.
  always_comb begin
    oe    = OutNone;
    op    = 8'h00;
    up    = 1'b0;
    base  = 8'h00;
    x_nib = lo;
    if ((effect_i >= 8'h01) && (effect_i <= CmdBasicLast)) begin
      oe = effect_i;
      op = ((effect_i == CmdVolume) || (effect_i == CmdGlobalVol)) ? scaled : operand_i;
    end else if ((effect_i == CmdPanSlide) || (effect_i == CmdPanSlideAlt)) begin
      oe = CmdPanSlide;
      op = operand_i;
    end else if ((effect_i == CmdRetrig) || (effect_i == CmdKeepA) ||
                 (effect_i == CmdKeepB) || (effect_i == CmdTremor)) begin
      oe = effect_i;
      op = operand_i;
    end else if (effect_i == CmdTempo) begin
      if (operand_i != 8'h00) begin
        oe = OutSpeed;
        op = (operand_i < TempoMin) ? TempoMin : operand_i;
      end
    end else if (effect_i == CmdSpeed) begin
      if (operand_i != 8'h00) begin
        oe = OutSpeed;
        op = (operand_i > SpeedMax) ? SpeedMax : operand_i;
      end
    end else if (effect_i == CmdOffset) begin
      oe = OutOffset;
      op = operand_i;
    end else if (effect_i == CmdJump) begin
      oe = OutJump;
      op = operand_i;
    end else if ((effect_i >= CmdExtFirst) && (effect_i <= CmdExtLast)) begin
      oe = OutExtended;
      op = {effect_i[3:0], lo};
    end else if (effect_i == CmdArpeggio) begin
      if (operand_i != 8'h00) begin
        oe = OutNone;
        op = operand_i;
      end
    end else if (effect_i == CmdXFineUp) begin
      oe = OutXFine;
      op = BaseUp + {4'h0, lo};
    end else if (effect_i == CmdXFineDown) begin
      oe = OutXFine;
      op = BaseDown + {4'h0, lo};
    end else if ((effect_i == CmdPortaUp) || (effect_i == CmdPortaDown) ||
                 (effect_i == CmdPortaUpAlt) || (effect_i == CmdPortaDnAlt)) begin
      up   = (effect_i == CmdPortaUp) || (effect_i == CmdPortaUpAlt);
      base = up ? BaseUp : BaseDown;
      if (operand_i >= FineThreshold) begin
        if (hi == 4'hF) begin
          oe = OutExtended;
          op = base + {4'h0, lo};
        end else begin
          oe = OutXFine;
          op = base + ((effect_i <= CmdPortaDown) ? {5'h0, lo[3:1]} : {4'h0, lo});
        end
      end else if (operand_i != 8'h00) begin
        oe = up ? OutPortaUp : OutPortaDown;
        op = operand_i;
      end
    end else if ((effect_i == CmdVolSlideUp) || (effect_i == CmdVolSlideDn)) begin
      base = (effect_i == CmdVolSlideUp) ? BaseFineVolUp : BaseFineVolDn;
      if (operand_i >= FineThreshold) begin
        oe = OutExtended;
        op = base + ((hi == 4'hF) ? {4'h0, lo} : {6'h0, lo[3:2]});
      end else if (operand_i != 8'h00) begin
        oe = OutVolSlide;
        op = (effect_i == CmdVolSlideUp) ? {operand_i[5:2], 4'h0} : {4'h0, operand_i[5:2]};
      end
    end else if (effect_i == CmdVolSlide) begin
      if (operand_i != 8'h00) begin
        if (!bad_a) begin
          if ((lo != 4'h0) && (hi != 4'h0)) begin
            x_nib = 4'h0;
          end
          if (hi != 4'h0) begin
            oe = OutVolSlide;
            op = {hi, 4'h0};
          end else if (x_nib != 4'h0) begin
            oe = OutVolSlide;
            op = {4'h0, x_nib};
          end
        end else if (!bad_b) begin
          if (lo == 4'hF) begin
            oe = OutExtended;
            op = BaseFineVolUp + {4'h0, hi};
          end else if (hi == 4'hF) begin
            oe = OutExtended;
            op = BaseFineVolDn + {4'h0, lo};
          end
        end
      end
    end else if ((effect_i == CmdFineVolUp) || (effect_i == CmdFineVolDn)) begin
      oe = OutExtended;
      op = fine_vol + ((effect_i == CmdFineVolUp) ? BaseFineVolUp : BaseFineVolDn);
    end else if (effect_i == CmdSlideUpQtr) begin
      oe = OutPortaUp;
      op = {2'b0, operand_i[7:2]};
    end else if (effect_i == CmdSlideDnQtr) begin
      oe = OutPortaDown;
      op = {2'b0, operand_i[7:2]};
    end
  end

  assign effect_o  = oe;
  assign operand_o = op;

endmodule

@@ hdl/tet_checker.sv @@
`include "assert_macros.svh"

module tet_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input tet_pkg::cmd_t effect_in_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input tet_pkg::cmd_t effect_out_o,
  input tet_pkg::cmd_t operand_out_o
);
  import tet_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // No result is offered in the cycle after reset is seen low.
  `ASSERT_CLK_ANY(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

  // The input side only stalls when a result is waiting on a stalled receiver.
  `ASSERT_CLK(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i))

  // A stalled result stays offered and unchanged.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(effect_out_o) &&
    $stable(operand_out_o)))

  // An accepted item reaches the output when the receiver does not stall while it sits in the input register.
  `ASSERT_CLK(a_latency, clk_i, rst_ni, (in_xfer ##1 !out_stall_i) |=> out_valid_o)

  // An unknown command code of zero gives an empty result.
  `ASSERT_CLK(a_zero_cmd, clk_i, rst_ni,
    ((in_xfer && (effect_in_i == OutNone)) ##1 !out_stall_i) |=>
    ((effect_out_o == OutNone) && (operand_out_o == 8'h00)))

endmodule

bind tracker_effect_translator tet_checker u_tet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .effect_in_i   (effect_in_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .effect_out_o  (effect_out_o),
  .operand_out_o (operand_out_o)
);
